[rtl/core/fde_pkg.sv]
package fde_pkg;

    // Status codes carried by the final item of a message.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INV_ENC   = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;
    localparam logic [1:0] ST_TOO_SHORT = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_MIN_LENGTH = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

    localparam int CFG_W = 16;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;

    // Queue between decoder and expander.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    // Expansion beat index; the longest expansion is five beats.
    localparam int IDX_W = 3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW
    } t_phase;

    typedef struct packed {
        logic       is_status;
        logic [7:0] data;
        logic [1:0] code;
    } t_op;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic passes_through(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || c == CH_STAR || c == CH_DASH ||
               c == CH_UNDER;
    endfunction

    // Number of output beats that one queued op expands into.
    function automatic logic [IDX_W-1:0] op_len(input t_op op);
        logic [IDX_W-1:0] n;
        n = IDX_W'(1);
        if (!op.is_status) begin
            if (op.data == CH_AMP) begin
                n = IDX_W'(5);
            end else if (op.data == CH_LT || op.data == CH_GT) begin
                n = IDX_W'(4);
            end
        end
        return n;
    endfunction

    // Character at beat idx of the HTML-escaped form of a data byte.
    function automatic logic [7:0] esc_char(input logic [7:0] b,
                                            input logic [IDX_W-1:0] idx);
        logic [7:0] ch;
        ch = b;
        if (b == CH_AMP) begin
            unique case (idx)
                3'd0:    ch = "&";
                3'd1:    ch = "a";
                3'd2:    ch = "m";
                3'd3:    ch = "p";
                default: ch = ";";
            endcase
        end else if (b == CH_LT || b == CH_GT) begin
            unique case (idx)
                3'd0:    ch = "&";
                3'd1:    ch = (b == CH_LT) ? 8'h6C : 8'h67;
                3'd2:    ch = "t";
                default: ch = ";";
            endcase
        end
        return ch;
    endfunction

endpackage

[rtl/core/fde_front.sv]
module fde_front #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_is_end,
    input  logic [15:0]           i_min_length,
    input  logic [15:0]           i_max_length,
    output logic                  o_push,
    output fde_pkg::t_op          o_op
);
    import fde_pkg::*;

    localparam int CW = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;

    t_phase                 r_phase, n_phase;
    logic [3:0]             r_high, n_high;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic [1:0]             r_err, n_err;

    t_hex                   hex;
    logic                   pass_ok;
    logic [7:0]             esc_byte;
    logic [CW-1:0]          count_ext, max_ext, min_ext, mask_ext, limit;
    logic                   too_long;

    assign hex       = hex_decode(i_in_byte);
    assign pass_ok   = passes_through(i_in_byte);
    assign esc_byte  = {r_high, hex.val};
    assign count_ext = CW'(r_count);
    assign max_ext   = CW'(i_max_length);
    assign min_ext   = CW'(i_min_length);
    assign mask_ext  = CW'({LENGTH_BITS{1'b1}});
    assign limit     = (max_ext < mask_ext) ? max_ext : mask_ext;
    assign too_long  = count_ext >= limit;

    // Escape sequencing.
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (i_is_end) begin
                n_phase = PH_IDLE;
            end else if (r_err == ST_OK) begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (!too_long && i_in_byte == CH_PERCENT) n_phase = PH_HIGH;
                    end
                    PH_HIGH: begin
                        if (hex.ok) n_phase = PH_LOW;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // Decoded ops, count and first error.
    always_comb begin
        n_high  = r_high;
        n_count = r_count;
        n_err   = r_err;
        o_push  = 1'b0;
        o_op    = '0;
        if (i_accept) begin
            if (i_is_end) begin
                o_push         = 1'b1;
                o_op.is_status = 1'b1;
                if (r_err != ST_OK) begin
                    o_op.code = r_err;
                end else if (r_phase != PH_IDLE) begin
                    o_op.code = ST_INV_ENC;
                end else if (count_ext < min_ext) begin
                    o_op.code = ST_TOO_SHORT;
                end else begin
                    o_op.code = ST_OK;
                end
                n_high  = 4'd0;
                n_count = '0;
                n_err   = ST_OK;
            end else if (r_err == ST_OK) begin
                unique case (r_phase)
                    PH_HIGH: begin
                        if (hex.ok) n_high = hex.val;
                        else        n_err  = ST_INV_ENC;
                    end
                    PH_LOW: begin
                        if (!hex.ok || esc_byte == 8'd0) begin
                            n_err = ST_INV_ENC;
                        end else begin
                            o_push    = 1'b1;
                            o_op.data = esc_byte;
                            n_count   = r_count + 1'b1;
                        end
                    end
                    default: begin
                        priority if (too_long) begin
                            n_err = ST_TOO_LONG;
                        end else if (i_in_byte == CH_PERCENT) begin
                            n_err = r_err;
                        end else if (i_in_byte == CH_PLUS) begin
                            o_push    = 1'b1;
                            o_op.data = CH_SPACE;
                            n_count   = r_count + 1'b1;
                        end else if (pass_ok) begin
                            o_push    = 1'b1;
                            o_op.data = i_in_byte;
                            n_count   = r_count + 1'b1;
                        end else begin
                            n_err = ST_INV_ENC;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_high  <= 4'd0;
            r_count <= '0;
            r_err   <= ST_OK;
        end else begin
            r_phase <= n_phase;
            r_high  <= n_high;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_is_end |=> r_count == '0 && r_err == ST_OK && r_phase == PH_IDLE)
        else $error("state not cleared after end beat");

    a_err_freezes_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_is_end && r_err != ST_OK |=> $stable(r_count) && $stable(r_err))
        else $error("state changed after first error");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && !o_op.is_status |-> count_ext < limit || r_phase == PH_LOW)
        else $error("data emitted past the length limit");

endmodule

[rtl/core/fde_fifo.sv]
module fde_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  fde_pkg::t_op i_op,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_empty,
    output fde_pkg::t_op o_op
);
    import fde_pkg::*;

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_PTR_W:0]   r_count, n_count;

    assign o_full  = r_count == (Q_PTR_W+1)'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_op    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_PTR_W'(i_push);
        n_rd_ptr = r_rd_ptr + Q_PTR_W'(i_pop);
        n_count  = r_count + (Q_PTR_W+1)'(i_push) - (Q_PTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_PTR_W+1)'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

[rtl/core/fde_back.sv]
module fde_back (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_empty,
    input  fde_pkg::t_op i_q_op,
    output logic         o_pop,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic         o_is_status,
    output logic [7:0]   o_out_byte,
    output logic [1:0]   o_status_code,
    output logic         o_last
);
    import fde_pkg::*;

    logic             r_valid, n_valid;
    t_op              r_op, n_op;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] len;
    logic             fire;
    logic             last_beat;

    assign len       = op_len(r_op);
    assign last_beat = r_idx == len - 1'b1;
    assign fire      = r_valid && !i_out_stall;

    // A new op is taken when the output holds nothing or its final beat leaves.
    always_comb begin
        n_valid = r_valid;
        n_op    = r_op;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        if (!r_valid || (fire && last_beat)) begin
            o_pop   = !i_q_empty;
            n_valid = !i_q_empty;
            n_op    = i_q_op;
            n_idx   = '0;
        end else if (fire) begin
            n_idx = r_idx + 1'b1;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_is_status   = r_op.is_status;
    assign o_out_byte    = r_op.is_status ? 8'd0 : esc_char(r_op.data, r_idx);
    assign o_status_code = r_op.is_status ? r_op.code : ST_OK;
    assign o_last        = last_beat;

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_idx < len)
        else $error("beat index past expansion length");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_out_stall |=> r_valid && $stable(r_idx) && $stable(r_op))
        else $error("output beat changed while stalled");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_op.is_status |-> last_beat)
        else $error("status item spans more than one beat");

endmodule

[rtl/core/form_decode_html_escape.sv]
// Form decoder with HTML escaping.
// The decoder pushes each op straight into a 4-entry op queue and the expander loads the
// queue head into its output register. Throughput: one input beat per cycle while the
// queue is not full and one output beat per cycle unless stalled; '&' gives 5 beats, '<' or '>' 4.
// Reset (synchronous, active low) clears all decode state and the queue, and sets
// min_length to 0 and max_length to 65535.
module form_decode_html_escape #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_is_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_status,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status_code,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import fde_pkg::*;

    logic [15:0] r_min_length;
    logic [15:0] r_max_length;

    logic        accept;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    t_op         push_op;
    t_op         head_op;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign accept      = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= 16'd0;
            r_max_length <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_LENGTH: r_min_length <= i_cfg_data;
                default:        r_max_length <= i_cfg_data;
            endcase
        end
    end

    fde_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_in_byte    (i_in_byte),
        .i_is_end     (i_is_end),
        .i_min_length (r_min_length),
        .i_max_length (r_max_length),
        .o_push       (push),
        .o_op         (push_op)
    );

    fde_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_op    (head_op)
    );

    fde_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_op        (head_op),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_is_status   (o_is_status),
        .o_out_byte    (o_out_byte),
        .o_status_code (o_status_code),
        .o_last        (o_last)
    );

endmodule

[bench/form_decode_html_escape_tb.sv]
`timescale 1ns / 1ps

module form_decode_html_escape_tb;
    import fde_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 250;

    typedef struct packed {
        logic       is_status;
        logic [7:0] data;
        logic [1:0] code;
        logic       last;
    } t_out_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_in_byte;
    logic        i_is_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_is_status;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_status_code;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    // Predictor state and its copy of the limit registers.
    logic [15:0] cfg_min;
    logic [15:0] cfg_max;
    t_phase      pend_phase;
    logic [3:0]  pend_high;
    logic [15:0] decoded_n;
    logic [1:0]  first_err;

    t_out_beat expected_beats[$];

    int items_sent;
    int data_beats;
    int status_seen[4];
    int mismatches;
    int quiet_cycles;
    int burst_left;
    int hold_requests;
    int holds_served;
    int limit_phases;

    form_decode_html_escape u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .i_is_end      (i_is_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_is_status   (o_is_status),
        .o_out_byte    (o_out_byte),
        .o_status_code (o_status_code),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return {1'b1, 4'(c - 8'h30)};
        end else if (c >= "A" && c <= "F") begin
            return {1'b1, 4'(c - 8'h37)};
        end else if (c >= "a" && c <= "f") begin
            return {1'b1, 4'(c - 8'h57)};
        end
        return 5'd0;
    endfunction

    function automatic logic is_plain(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == CH_STAR || c == CH_DASH ||
               c == CH_UNDER;
    endfunction

    function automatic void expect_beat(input logic st, input logic [7:0] d,
                                        input logic [1:0] code, input logic last);
        t_out_beat b;
        b.is_status = st;
        b.data      = d;
        b.code      = code;
        b.last      = last;
        expected_beats.push_back(b);
    endfunction

    function automatic void html_expand(input logic [7:0] b);
        string txt;
        if (b == CH_AMP) begin
            txt = "&amp;";
        end else if (b == CH_LT) begin
            txt = "&lt;";
        end else if (b == CH_GT) begin
            txt = "&gt;";
        end else begin
            txt = " ";
            txt[0] = b;
        end
        for (int i = 0; i < txt.len(); i++) begin
            expect_beat(1'b0, txt[i], ST_OK, i == txt.len() - 1);
        end
        decoded_n = decoded_n + 16'd1;
    endfunction

    function automatic void predict_item(input logic [7:0] c, input logic e);
        logic [1:0] code;
        logic [4:0] h;
        logic [7:0] b;
        code = first_err;
        h    = hex_digit(c);
        b    = {pend_high, h[3:0]};
        if (e) begin
            if (code == ST_OK && pend_phase != PH_IDLE) begin
                code = ST_INV_ENC;
            end else if (code == ST_OK && decoded_n < cfg_min) begin
                code = ST_TOO_SHORT;
            end
            expect_beat(1'b1, 8'h00, code, 1'b1);
            pend_phase = PH_IDLE;
            pend_high  = 4'd0;
            decoded_n  = 16'd0;
            first_err  = ST_OK;
        end else if (first_err == ST_OK) begin
            if (pend_phase == PH_HIGH) begin
                if (!h[4]) begin
                    first_err = ST_INV_ENC;
                end else begin
                    pend_high  = h[3:0];
                    pend_phase = PH_LOW;
                end
            end else if (pend_phase == PH_LOW) begin
                pend_phase = PH_IDLE;
                if (!h[4] || b == 8'h00) begin
                    first_err = ST_INV_ENC;
                end else begin
                    html_expand(b);
                end
            end else if (decoded_n >= cfg_max) begin
                first_err = ST_TOO_LONG;
            end else if (c == CH_PERCENT) begin
                pend_phase = PH_HIGH;
            end else if (c == CH_PLUS) begin
                html_expand(CH_SPACE);
            end else if (is_plain(c)) begin
                html_expand(c);
            end else begin
                first_err = ST_INV_ENC;
            end
        end
    endfunction

    // ---------------------------------------------------------------- monitors

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_item(i_in_byte, i_is_end);
            items_sent++;
        end
    end

    always @(posedge i_clk) begin
        t_out_beat got;
        t_out_beat want;
        got = {o_is_status, o_out_byte, o_status_code, o_last};
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (o_is_status) begin
                status_seen[o_status_code]++;
            end else begin
                data_beats++;
            end
            if (expected_beats.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected beat: status=%0d byte=%02h code=%0d last=%0d",
                             got.is_status, got.data, got.code, got.last);
                end
                mismatches++;
            end else begin
                want = expected_beats.pop_front();
                if (got.is_status !== want.is_status || got.data !== want.data ||
                    got.code !== want.code || got.last !== want.last) begin
                    if (mismatches < 10) begin
                        $display("mismatch: expected status=%0d byte=%02h code=%0d last=%0d",
                                 want.is_status, want.data, want.code, want.last);
                        $display("          actual   status=%0d byte=%02h code=%0d last=%0d",
                                 got.is_status, got.data, got.code, got.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    // A run where nothing moves on any channel for too long is a hang.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles, %0d beats still due",
                     QUIET_LIMIT, expected_beats.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Output stall pattern: random modes of random length, plus long hold-offs on request.
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 150);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_item(input logic [7:0] c, input logic e);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= c;
        i_is_end   <= e;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
    endtask

    task automatic send_message(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], 1'b0);
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Stop offering and wait until every expected beat has come out, then let
    // bytes that cause no output settle inside the block.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [15:0] min_v, input logic [15:0] max_v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MIN_LENGTH;
        i_cfg_data  <= min_v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_min = min_v;
        i_cfg_index <= CFG_MAX_LENGTH;
        i_cfg_data  <= max_v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_max = max_v;
        i_cfg_valid <= 1'b0;
        limit_phases++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10) begin
            return 8'h30 + 8'(v);
        end
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] plain_char();
        case ($urandom_range(0, 5))
            0:       return 8'h30 + 8'($urandom_range(0, 9));
            1:       return 8'h41 + 8'($urandom_range(0, 25));
            2:       return 8'h61 + 8'($urandom_range(0, 25));
            3:       return CH_STAR;
            4:       return CH_DASH;
            default: return CH_UNDER;
        endcase
    endfunction

    task automatic send_escape(input logic [7:0] b);
        send_item(CH_PERCENT, 1'b0);
        send_item(hex_char(b[7:4], 1'($urandom_range(0, 1))), 1'b0);
        send_item(hex_char(b[3:0], 1'($urandom_range(0, 1))), 1'b0);
    endtask

    task automatic send_token();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            6: send_item(CH_PLUS, 1'b0);
            7, 8, 9: begin
                case ($urandom_range(0, 5))
                    0:       b = CH_AMP;
                    1:       b = CH_LT;
                    2:       b = CH_GT;
                    default: b = 8'($urandom_range(1, 255));
                endcase
                send_escape(b);
            end
            default: send_item(plain_char(), 1'b0);
        endcase
    endtask

    // Mostly well-formed strings; the rest are raw noise or strings that break
    // off in a bad escape.
    task automatic send_random_message();
        int kind;
        int n;
        logic [7:0] c;
        kind = $urandom_range(0, 9);
        n = $urandom_range(0, 10);
        if (kind < 8) begin
            repeat (n) send_token();
        end else if (kind == 8) begin
            repeat (n + 1) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_item(8'($urandom_range(0, 255)), 1'b0);
                end else begin
                    send_token();
                end
            end
        end else begin
            repeat (n) send_token();
            case ($urandom_range(0, 4))
                0: begin
                    do c = 8'($urandom_range(0, 255)); while (hex_digit(c) != 5'd0);
                    send_item(CH_PERCENT, 1'b0);
                    send_item(c, 1'b0);
                end
                1: begin
                    do c = 8'($urandom_range(0, 255)); while (hex_digit(c) != 5'd0);
                    send_item(CH_PERCENT, 1'b0);
                    send_item(hex_char(4'($urandom_range(0, 15)), 1'b1), 1'b0);
                    send_item(c, 1'b0);
                end
                2: send_escape(8'h00);
                3: begin
                    send_item(CH_PERCENT, 1'b0);
                    send_item(hex_char(4'($urandom_range(0, 15)), 1'b0), 1'b0);
                end
                default: send_item(CH_PERCENT, 1'b0);
            endcase
            if ($urandom_range(0, 1) == 0) begin
                repeat ($urandom_range(1, 3)) send_token();
            end
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_plain_and_escapes();
        send_message("Az9*-_+");
        send_message("%26%3c%3E");
        send_message("%00");
        send_message("%4");
        send_message("\377a");
        send_message("");
        drain();
    endtask

    task automatic test_length_limits();
        set_limits(16'd3, 16'd5);
        send_message("ab");
        send_message("abcde");
        send_message("abcde%41");
        set_limits(16'd0, 16'd0);
        send_message("a");
        send_message("");
        set_limits(16'd2, 16'd3);
        send_message("a%26b");
        send_message("ab%41c");
        set_limits(16'hFFFF, 16'hFFFF);
        send_message("x");
        set_limits(16'd0, 16'hFFFF);
    endtask

    // The output side holds off for a long stretch while '&' escapes keep
    // arriving, so the op queue fills and the input must stall.
    task automatic test_long_hold();
        hold_requests++;
        burst_left = 200;
        repeat (12) send_escape(CH_AMP);
        send_message("ok");
        drain();
    endtask

    task automatic test_random_messages();
        int target;
        int phase_end;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            case ($urandom_range(0, 3))
                0: set_limits(16'd0, 16'hFFFF);
                1: set_limits(16'($urandom_range(0, 6)), 16'($urandom_range(0, 12)));
                2: set_limits(16'd0, 16'($urandom_range(0, 3)));
                default: set_limits(16'($urandom_range(0, 4)), 16'hFFFF);
            endcase
            phase_end = items_sent + 50;
            while (items_sent < phase_end && items_sent < target) begin
                send_random_message();
                if ($urandom_range(0, 15) == 0) begin
                    drain();
                end
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_byte   = 8'h00;
        i_is_end    = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MIN_LENGTH;
        i_cfg_data  = 16'h0000;
        cfg_min     = 16'd0;
        cfg_max     = 16'hFFFF;
        pend_phase  = PH_IDLE;
        pend_high   = 4'd0;
        decoded_n   = 16'd0;
        first_err   = ST_OK;
        items_sent  = 0;
        data_beats  = 0;
        mismatches  = 0;
        burst_left  = 0;
        hold_requests = 0;
        holds_served  = 0;
        limit_phases  = 0;
        for (int i = 0; i < 4; i++) status_seen[i] = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_and_escapes();
        test_length_limits();
        test_long_hold();
        test_random_messages();
        drain();

        if (expected_beats.size() != 0) begin
            mismatches += expected_beats.size();
        end
        $display("covered %0d source bytes and end marks over %0d limit settings",
                 items_sent, limit_phases);
        $display("saw %0d data beats; status ok/encoding/long/short = %0d/%0d/%0d/%0d",
                 data_beats, status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3]);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d failing beats", mismatches);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[form_decode_html_escape.f]
rtl/core/fde_pkg.sv
rtl/core/fde_front.sv
rtl/core/fde_fifo.sv
rtl/core/fde_back.sv
rtl/core/form_decode_html_escape.sv
bench/form_decode_html_escape_tb.sv
